[hw/rtl/hlcd_pkg.sv]
// Package with the shared types, constants and CRC function of the frame deframer.
package hlcd_pkg;

    localparam int PAYLOAD_LIMIT_DEF = 256;

    localparam logic [7:0]  HDR_FIRST_RST   = 8'hAA;
    localparam logic [7:0]  HDR_SECOND_RST  = 8'h55;
    localparam logic [8:0]  MAX_PAYLOAD_RST = 9'd256;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    typedef enum logic [1:0] {
        CFG_HDR_FIRST   = 2'd0,
        CFG_HDR_SECOND  = 2'd1,
        CFG_MAX_PAYLOAD = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_SYNC0  = 3'd0,
        PH_SYNC1  = 3'd1,
        PH_CMD    = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_BODY   = 3'd5,
        PH_CRC_LO = 3'd6,
        PH_CRC_HI = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_LEN_ERR = 2'd2,
        KIND_CRC_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic [7:0]  command;
        logic [15:0] length;
        logic        last;
    } t_result;

    // One byte of the reflected CRC-16 update, unrolled over eight bit steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/header_length_crc_deframer.sv]
// Top level of the frame deframer: sync hunt, header fields, payload pass-through and CRC check.
//
//   Channel   Direction  Handshake            Word
//   input     in         i_valid / o_stall    i_rx_byte
//   result    out        o_valid / i_stall    o_kind, o_data, o_index, o_command, o_length, o_last
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_stall is low; its result is registered in r_out or r_skid.
// The frame state and the eight-step CRC update settle in the same cycle the byte is accepted.
// Reset is synchronous and active low; it restores the config and frame registers and the sync hunt.
// A stalled output keeps its word and the next result goes into a one-word skid register.
// The input stalls only while that skid register is occupied.
module header_length_crc_deframer #(
    parameter int PAYLOAD_LIMIT = hlcd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [7:0]  o_index,
    output logic [7:0]  o_command,
    output logic [15:0] o_length,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int         CW      = $clog2(PAYLOAD_LIMIT + 1);
    localparam logic [16:0] LIMIT_W = 17'(PAYLOAD_LIMIT);

    logic [7:0]  r_hdr_first;
    logic [7:0]  r_hdr_second;
    logic [8:0]  r_max_payload;

    hlcd_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_command, n_command;
    logic [15:0] r_length, n_length;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]  r_crc_low, n_crc_low;
    logic [15:0] r_crc, n_crc;

    hlcd_pkg::t_result r_out, r_skid, res;
    logic        r_out_valid, r_skid_valid;
    logic        res_valid;

    logic        accept;
    logic        take;
    logic [15:0] crc_next;
    logic [15:0] len_full;
    logic [16:0] limit_eff;
    logic [CW:0] count_inc;
    logic [15:0] rx_crc;

    assign accept    = i_valid && !o_stall;
    assign take      = r_out_valid && !i_stall;
    assign o_stall   = r_skid_valid;
    assign crc_next  = hlcd_pkg::crc16_byte(r_crc, i_rx_byte);
    assign len_full  = {i_rx_byte, r_length[7:0]};
    assign limit_eff = ({8'd0, r_max_payload} < LIMIT_W) ? {8'd0, r_max_payload} : LIMIT_W;
    assign count_inc = {1'b0, r_count} + (CW + 1)'(1);
    assign rx_crc    = {i_rx_byte, r_crc_low};

    // Next frame state for one accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_length  = r_length;
        n_count   = r_count;
        n_crc_low = r_crc_low;
        n_crc     = r_crc;
        case (r_phase)
            hlcd_pkg::PH_SYNC0: begin
                if (i_rx_byte == r_hdr_first) begin
                    n_phase = hlcd_pkg::PH_SYNC1;
                end
            end
            hlcd_pkg::PH_SYNC1: begin
                if (i_rx_byte == r_hdr_second) begin
                    n_phase = hlcd_pkg::PH_CMD;
                    n_crc   = hlcd_pkg::CRC_INIT;
                end else if (i_rx_byte != r_hdr_first) begin
                    n_phase = hlcd_pkg::PH_SYNC0;
                end
            end
            hlcd_pkg::PH_CMD: begin
                n_command = i_rx_byte;
                n_crc     = crc_next;
                n_phase   = hlcd_pkg::PH_LEN_LO;
            end
            hlcd_pkg::PH_LEN_LO: begin
                n_length = {8'd0, i_rx_byte};
                n_crc    = crc_next;
                n_phase  = hlcd_pkg::PH_LEN_HI;
            end
            hlcd_pkg::PH_LEN_HI: begin
                n_length = len_full;
                n_crc    = crc_next;
                n_count  = '0;
                if ({1'b0, len_full} > limit_eff) begin
                    n_phase   = hlcd_pkg::PH_SYNC0;
                    n_command = '0;
                    n_length  = '0;
                    n_crc_low = '0;
                    n_crc     = hlcd_pkg::CRC_INIT;
                end else if (len_full == 16'd0) begin
                    n_phase = hlcd_pkg::PH_CRC_LO;
                end else begin
                    n_phase = hlcd_pkg::PH_BODY;
                end
            end
            hlcd_pkg::PH_BODY: begin
                n_crc   = crc_next;
                n_count = count_inc[CW-1:0];
                if (17'(count_inc) >= {1'b0, r_length}) begin
                    n_phase = hlcd_pkg::PH_CRC_LO;
                end
            end
            hlcd_pkg::PH_CRC_LO: begin
                n_crc_low = i_rx_byte;
                n_phase   = hlcd_pkg::PH_CRC_HI;
            end
            default: begin
                n_phase   = hlcd_pkg::PH_SYNC0;
                n_command = '0;
                n_length  = '0;
                n_count   = '0;
                n_crc_low = '0;
                n_crc     = hlcd_pkg::CRC_INIT;
            end
        endcase
    end

    // Result word for one accepted byte.
    always_comb begin
        res_valid   = 1'b0;
        res.kind    = hlcd_pkg::KIND_DATA;
        res.data    = '0;
        res.index   = '0;
        res.command = r_command;
        res.length  = r_length;
        res.last    = 1'b0;
        case (r_phase)
            hlcd_pkg::PH_LEN_HI: begin
                res.length = len_full;
                if ({1'b0, len_full} > limit_eff) begin
                    res_valid = 1'b1;
                    res.kind  = hlcd_pkg::KIND_LEN_ERR;
                    res.last  = 1'b1;
                end
            end
            hlcd_pkg::PH_BODY: begin
                res_valid = 1'b1;
                res.data  = i_rx_byte;
                res.index = 8'(r_count);
            end
            hlcd_pkg::PH_CRC_HI: begin
                res_valid = 1'b1;
                res.kind  = (rx_crc == r_crc) ? hlcd_pkg::KIND_GOOD : hlcd_pkg::KIND_CRC_ERR;
                res.last  = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
        res_valid = res_valid && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first   <= hlcd_pkg::HDR_FIRST_RST;
            r_hdr_second  <= hlcd_pkg::HDR_SECOND_RST;
            r_max_payload <= hlcd_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hlcd_pkg::CFG_HDR_FIRST:   r_hdr_first   <= i_cfg_data[7:0];
                hlcd_pkg::CFG_HDR_SECOND:  r_hdr_second  <= i_cfg_data[7:0];
                hlcd_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hlcd_pkg::PH_SYNC0;
            r_command <= '0;
            r_length  <= '0;
            r_count   <= '0;
            r_crc_low <= '0;
            r_crc     <= hlcd_pkg::CRC_INIT;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_command <= n_command;
            r_length  <= n_length;
            r_count   <= n_count;
            r_crc_low <= n_crc_low;
            r_crc     <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
                if (res_valid) begin
                    r_out <= res;
                end
            end
        end else if (res_valid) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_kind    = r_out.kind;
    assign o_data    = r_out.data;
    assign o_index   = r_out.index;
    assign o_command = r_out.command;
    assign o_length  = r_out.length;
    assign o_last    = r_out.last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid word held without an output word.");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("Skid register filled while the output was free.");

    a_last_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind != hlcd_pkg::KIND_DATA)))
        else $error("Last flag does not match the result kind.");

    a_verdict_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == hlcd_pkg::PH_CRC_HI) |=> (r_phase == hlcd_pkg::PH_SYNC0))
        else $error("Frame did not return to the sync hunt after its verdict.");

endmodule
